// ===== rtl/sfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stutter roll feedback delay.
package sfd_pkg;

	localparam int SMP_W  = 16;
	localparam int BEAT_W = 14;
	localparam int LVL_W  = 16;
	localparam int RATE_W = 18;
	localparam int GAIN_W = 17;   // 0..32768
	localparam int PROD_W = 34;   // sample x gain product
	localparam int LEN_W  = 23;   // beat*rate/1000 fits 23 bits

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
	localparam logic [GAIN_W-1:0] FULL_Q15   = 17'd32768;
	localparam logic signed [SMP_W-1:0] FEEDBACK_Q15 = 16'sd31130;

	// floor(x/1000) = floor((x>>3)/125); reciprocal of 125 scaled by 2^32
	localparam logic [25:0] DIV125_MUL = 26'd34359738;
	localparam logic [6:0]  DIV125     = 7'd125;

	localparam int OFIFO_DEPTH = 16;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CW    = OFIFO_AW + 1;

	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	typedef struct packed {
		pair_t             smp;
		logic              hold;
		logic              rise;
		logic [GAIN_W-1:0] wet;
		logic [GAIN_W-1:0] dry;
	} item_t;

	function automatic sample_t sat16(input logic signed [35:0] v);
		sample_t r;
		if (v > 36'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -36'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// input + round(0.95 * delayed), saturated
	function automatic sample_t fb_store(input sample_t in_s, input sample_t dly);
		logic signed [31:0] p;
		logic signed [16:0] f;
		logic signed [17:0] s;
		p = dly * FEEDBACK_Q15;
		p = p + 32'sd16384;
		f = p[31:15];
		s = 18'(in_s) + 18'(f);
		return sat16(36'(s));
	endfunction

	// round-half-up of (dry product + wet product) / 32768, saturated
	function automatic sample_t mix_round(input prod_t a, input prod_t b);
		logic signed [34:0] s;
		s = 35'(a) + 35'(b) + 35'sd16384;
		return sat16(36'($signed(s[34:15])));
	endfunction

endpackage

// ===== rtl/sfd_in_if.sv =====
// Input sample channel: valid/ready plus one stereo item with control fields.
interface sfd_in_if;
	logic                         valid;
	logic                         ready;
	sfd_pkg::sample_t             in_left;
	sfd_pkg::sample_t             in_right;
	logic [sfd_pkg::BEAT_W-1:0]   beat_ms;
	logic [sfd_pkg::LVL_W-1:0]    level_depth;
	logic                         fx_on;

	modport source (output valid, in_left, in_right, beat_ms, level_depth, fx_on,
		input ready);
	modport sink (input valid, in_left, in_right, beat_ms, level_depth, fx_on,
		output ready);
endinterface

// ===== rtl/sfd_out_if.sv =====
// Output sample channel: valid/ready plus one stereo result.
interface sfd_out_if;
	logic             valid;
	logic             ready;
	sfd_pkg::sample_t out_left;
	sfd_pkg::sample_t out_right;

	modport source (output valid, out_left, out_right, input ready);
	modport sink (input valid, out_left, out_right, output ready);
endinterface

// ===== rtl/sfd_loop_len.sv =====
// Beat-to-samples pipeline: beat_ms*rate/1000, clamped to 1..depth-1, three stages.
module sfd_loop_len #(
	parameter int DELAY_DEPTH = 131072
) (
	input  logic                              clk,
	input  logic [sfd_pkg::BEAT_W-1:0]        beat,
	input  logic [sfd_pkg::RATE_W-1:0]        rate,
	output logic [$clog2(DELAY_DEPTH)-1:0]    delay
);
	import sfd_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DELAY_DEPTH - 1);

	logic [31:0]      prod_s2;
	logic [28:0]      y_s3;
	logic [LEN_W-1:0] q0_s3;
	logic [LEN_W-1:0] q_s4;

	logic [54:0]      ym;
	logic [29:0]      back;
	logic [28:0]      rem;

	assign ym   = prod_s2[31:3] * DIV125_MUL;
	assign back = q0_s3 * DIV125;
	assign rem  = y_s3 - back[28:0];

	always_ff @(posedge clk) begin
		prod_s2 <= beat * rate;
		y_s3    <= prod_s2[31:3];
		q0_s3   <= ym[54:32];
		// estimate is low by at most one
		q_s4    <= (rem >= 29'(DIV125)) ? q0_s3 + 1'b1 : q0_s3;
	end

	always_comb begin
		if (q_s4 == '0) begin
			delay = AW'(1);
		end else if (q_s4 > LEN_MAX) begin
			delay = LEN_MAX[AW-1:0];
		end else begin
			delay = q_s4[AW-1:0];
		end
	end
endmodule

// ===== rtl/sfd_out_fifo.sv =====
// Result queue between the pipeline and the output channel.
module sfd_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::pair_t  push_data,
	sfd_out_if.source       out_ch
);
	import sfd_pkg::*;

	pair_t                 mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]   wr_ptr_q;
	logic [OFIFO_AW-1:0]   rd_ptr_q;
	logic [OFIFO_CW-1:0]   count_q;
	logic                  pop;

	assign out_ch.valid     = (count_q != '0);
	assign out_ch.out_left  = mem_q[rd_ptr_q].left;
	assign out_ch.out_right = mem_q[rd_ptr_q].right;
	assign pop              = out_ch.valid & out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/stutter_roll_feedback_delay_core.sv =====
// Top level of the stereo stutter roll feedback delay.
//
// Usage:
//   sample_in  : one stereo pair per transfer, with beat_ms, level_depth, fx_on.
//   sample_out : one stereo pair per input transfer, in order.
//   cfg_we/cfg_wdata : sample rate in Hz, written while the block is idle.
// Throughput: one transfer per cycle, sustained while the result queue has room.
//   An input transfer passes stage registers s1 to s8, then the result queue.
// The delay length beat_ms*rate/1000 takes three stages (multiply, reciprocal
//   multiply, correct) and is latched in stage 4 on the item where fx_on rises.
// Ring stores: one dual-port RAM per channel, one read (stage 6) and one write
//   (stage 8) per cycle. Writes still in flight are forwarded into stage 7, so a
//   one-sample loop runs back to back through a single multiply-add-saturate.
// Reset: no clearing pass. The write position counts up from zero with a wrap
//   flag; an entry that has not been written yet reads as zero.
// Stall: a 16-entry result queue holds finished results; ready drops once 16
//   transfers are accepted but not yet taken, so nothing is dropped.
module stutter_roll_feedback_delay_core #(
	parameter int DELAY_DEPTH = 131072
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfd_pkg::RATE_W-1:0]  cfg_wdata,
	sfd_in_if.sink                      sample_in,
	sfd_out_if.source                   sample_out
);
	import sfd_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

	// control state
	logic [RATE_W-1:0]   rate_q;
	logic                prev_on_q;
	logic [OFIFO_CW-1:0] occ_q;
	logic [AW-1:0]       loop_delay_q;
	logic [AW-1:0]       wp_q;
	logic                wrap_q;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                wb_v_q;

	// payload pipeline
	item_t               it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;
	logic [BEAT_W-1:0]   beat_s1;
	logic [AW-1:0]       d_s5, wp_s5;
	logic                wrap_s5;
	logic [AW-1:0]       rp_s6, wp_s6, rp_s7, wp_s7, wp_s8;
	logic                unw_s6, unw_s7;
	sample_t             rdl_s7, rdr_s7;
	pair_t               wd_s8;
	prod_t               pdl_s8, pwl_s8, pdr_s8, pwr_s8;
	logic [AW-1:0]       wb_addr_q;
	pair_t               wb_data_q;

	// ring stores
	sample_t             left_mem [DELAY_DEPTH];
	sample_t             right_mem [DELAY_DEPTH];

	logic                in_xfer, out_xfer;
	logic [LVL_W-1:0]    lvl_c;
	item_t               in_item;
	logic [AW-1:0]       dly_s4, d_eff;
	logic [AW-1:0]       rp;
	logic                unw;
	pair_t               dl;
	pair_t               wd;
	pair_t               res;

	assign in_xfer          = sample_in.valid & sample_in.ready;
	assign out_xfer         = sample_out.valid & sample_out.ready;
	assign sample_in.ready  = (occ_q < OFIFO_CW'(OFIFO_DEPTH));

	// input decode: wet level clamp and rising edge of the effect switch
	assign lvl_c = (sample_in.level_depth > FULL_Q15[LVL_W-1:0] && FULL_Q15[LVL_W])
		? sample_in.level_depth : sample_in.level_depth;

	always_comb begin
		in_item.smp.left  = sample_in.in_left;
		in_item.smp.right = sample_in.in_right;
		in_item.hold      = sample_in.fx_on;
		in_item.rise      = sample_in.fx_on & ~prev_on_q;
		if ({1'b0, sample_in.level_depth} > FULL_Q15) begin
			in_item.wet = FULL_Q15;
		end else begin
			in_item.wet = {1'b0, lvl_c};
		end
		in_item.dry = FULL_Q15 - in_item.wet;
	end

	sfd_loop_len #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_len (
		.clk   (clk),
		.beat  (beat_s1),
		.rate  (rate_q),
		.delay (dly_s4)
	);

	// stage 4: the rising item uses its own fresh delay
	assign d_eff = it_s4.rise ? dly_s4 : loop_delay_q;

	// stage 5: read position and whether that slot was ever written
	assign unw = ~wrap_s5 & (d_s5 > wp_s5);
	assign rp  = (wp_s5 >= d_s5) ? (wp_s5 - d_s5)
		: AW'({1'b0, wp_s5} + DEPTH_X - {1'b0, d_s5});

	// stage 7: delayed sample, newest write first
	always_comb begin
		priority if (v_s8 && wp_s8 == rp_s7) begin
			dl = wd_s8;
		end else if (wb_v_q && wb_addr_q == rp_s7) begin
			dl = wb_data_q;
		end else if (unw_s7) begin
			dl = '0;
		end else begin
			dl.left  = rdl_s7;
			dl.right = rdr_s7;
		end
		if (it_s7.hold) begin
			wd.left  = fb_store(it_s7.smp.left, dl.left);
			wd.right = fb_store(it_s7.smp.right, dl.right);
		end else begin
			wd = it_s7.smp;
		end
	end

	// stage 8: dry/wet mix
	always_comb begin
		if (it_s8.hold) begin
			res.left  = mix_round(pdl_s8, pwl_s8);
			res.right = mix_round(pdr_s8, pwr_s8);
		end else begin
			res = it_s8.smp;
		end
	end

	sfd_out_fifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s8),
		.push_data (res),
		.out_ch    (sample_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q       <= RATE_RESET;
			prev_on_q    <= 1'b0;
			occ_q        <= '0;
			loop_delay_q <= '0;
			wp_q         <= '0;
			wrap_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			v_s7         <= 1'b0;
			v_s8         <= 1'b0;
			wb_v_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (in_xfer) begin
				prev_on_q <= sample_in.fx_on;
			end
			unique case ({in_xfer, out_xfer})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
			if (v_s4) begin
				if (wp_q == LAST_POS) begin
					wp_q   <= '0;
					wrap_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
				if (it_s4.rise) begin
					loop_delay_q <= dly_s4;
				end
			end
			v_s1   <= in_xfer;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			wb_v_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		it_s1     <= in_item;
		beat_s1   <= sample_in.beat_ms;
		it_s2     <= it_s1;
		it_s3     <= it_s2;
		it_s4     <= it_s3;
		it_s5     <= it_s4;
		d_s5      <= d_eff;
		wp_s5     <= wp_q;
		wrap_s5   <= wrap_q;
		it_s6     <= it_s5;
		rp_s6     <= rp;
		wp_s6     <= wp_s5;
		unw_s6    <= unw;
		it_s7     <= it_s6;
		rp_s7     <= rp_s6;
		wp_s7     <= wp_s6;
		unw_s7    <= unw_s6;
		it_s8     <= it_s7;
		wp_s8     <= wp_s7;
		wd_s8     <= wd;
		pdl_s8    <= it_s7.smp.left * $signed({1'b0, it_s7.dry});
		pwl_s8    <= dl.left * $signed({1'b0, it_s7.wet});
		pdr_s8    <= it_s7.smp.right * $signed({1'b0, it_s7.dry});
		pwr_s8    <= dl.right * $signed({1'b0, it_s7.wet});
		wb_addr_q <= wp_s8;
		wb_data_q <= wd_s8;
	end

	// ring store RAMs: read in stage 6, write in stage 8 (read returns old data)
	always_ff @(posedge clk) begin
		rdl_s7 <= left_mem[rp_s6];
		rdr_s7 <= right_mem[rp_s6];
		if (v_s8) begin
			left_mem[wp_s8]  <= wd_s8.left;
			right_mem[wp_s8] <= wd_s8.right;
		end
	end

	// outstanding transfers never exceed the result queue
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OFIFO_CW'(OFIFO_DEPTH))
		else $error("outstanding count above queue depth");

	// a held item always carries a delay in 1..depth-1
	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && it_s5.hold |-> d_s5 != '0 && d_s5 <= LAST_POS)
		else $error("held item with delay out of range");

	// a continuing hold follows a latched delay
	a_delay_latched: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && it_s4.hold && !it_s4.rise |-> loop_delay_q != '0)
		else $error("hold without a latched delay");

	// a slot marked never written cannot be pending in the write stage
	a_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && unw_s7 && v_s8 |-> wp_s8 != rp_s7)
		else $error("unwritten slot matches an in-flight write");

	// each pipeline item takes the position right after the last one
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && v_s6 && wp_s6 != LAST_POS |-> wp_s5 == wp_s6 + 1'b1)
		else $error("write position skipped");
endmodule

// ===== tb/sv/sfd_echo_checker.sv =====
// Scoreboard for the stutter roll feedback delay: echo prediction and result comparison.
module sfd_echo_checker #(
	parameter int DEPTH = 131072
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfd_pkg::RATE_W-1:0]  cfg_wdata,
	sfd_in_if                           feed,
	sfd_out_if                          echo,
	output int                          errors,
	output int                          pending
);
	import sfd_pkg::*;

	localparam longint FB_GAIN   = 31130;   // 0.95 in Q15
	localparam longint UNITY_Q15 = 32768;
	localparam int     MAX_SHOWN = 40;

	logic [RATE_W-1:0] rate;
	logic              roll_held;
	int unsigned       echo_delay;
	int unsigned       wr_pos;
	sample_t           left_ring [DEPTH];
	sample_t           right_ring [DEPTH];
	pair_t             echo_q [$];

	function automatic sample_t clip16(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return sample_t'(v);
	endfunction

	// new ring entry: input plus 0.95 of the tap, rounded half up
	function automatic sample_t decay_write(input sample_t x, input sample_t tap);
		longint fb;
		fb = (longint'(tap) * FB_GAIN + 16384) >>> 15;
		return clip16(longint'(x) + fb);
	endfunction

	function automatic sample_t blend(input sample_t x, input sample_t tap,
			input longint wet, input longint dry);
		return clip16((longint'(x) * dry + longint'(tap) * wet + 16384) >>> 15);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		if (errors < MAX_SHOWN)
			$display("ERROR %0t: %s expected %0d got %0d", $time, what, want, got);
		errors++;
	endtask

	task automatic predict_echo(input sample_t l, input sample_t r,
			input logic [BEAT_W-1:0] beat, input logic [LVL_W-1:0] lvl, input logic on);
		longint unsigned span;
		int unsigned     tap_pos;
		sample_t         tl;
		sample_t         tr;
		longint          wet;
		longint          dry;
		pair_t           res;
		if (on && !roll_held) begin
			span = (longint'(beat) * longint'(rate)) / 1000;
			if (span < 1)
				span = 1;
			if (span > DEPTH - 1)
				span = DEPTH - 1;
			echo_delay = int'(span);
			roll_held  = 1'b1;
		end else if (!on && roll_held) begin
			roll_held = 1'b0;
		end
		if (!roll_held) begin
			left_ring[wr_pos]  = l;
			right_ring[wr_pos] = r;
			res.left  = l;
			res.right = r;
		end else begin
			tap_pos = (wr_pos + DEPTH - echo_delay) % DEPTH;
			tl  = left_ring[tap_pos];
			tr  = right_ring[tap_pos];
			wet = (lvl > UNITY_Q15) ? UNITY_Q15 : longint'(lvl);
			dry = UNITY_Q15 - wet;
			left_ring[wr_pos]  = decay_write(l, tl);
			right_ring[wr_pos] = decay_write(r, tr);
			res.left  = blend(l, tl, wet, dry);
			res.right = blend(r, tr, wet, dry);
		end
		wr_pos = (wr_pos + 1) % DEPTH;
		echo_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pair_t want;
		if (!arst_n) begin
			rate       = RATE_RESET;
			roll_held  = 1'b0;
			echo_delay = 0;
			wr_pos     = 0;
			errors     = 0;
			echo_q.delete();
			foreach (left_ring[i]) begin
				left_ring[i]  = '0;
				right_ring[i] = '0;
			end
			pending <= 0;
		end else begin
			if (cfg_we)
				rate = cfg_wdata;
			if (feed.valid && feed.ready)
				predict_echo(feed.in_left, feed.in_right, feed.beat_ms, feed.level_depth,
					feed.fx_on);
			if (echo.valid && echo.ready) begin
				if (echo_q.size() == 0) begin
					report_mismatch("unexpected result, left", 0, echo.out_left);
				end else begin
					want = echo_q.pop_front();
					if (echo.out_left !== want.left)
						report_mismatch("out_left", want.left, echo.out_left);
					if (echo.out_right !== want.right)
						report_mismatch("out_right", want.right, echo.out_right);
				end
			end
			pending <= echo_q.size();
		end
	end

endmodule

// ===== tb/sv/stutter_roll_feedback_delay_core_tb.sv =====
// Top of the stutter roll feedback delay testbench: clock, reset, stimulus and verdict.
module stutter_roll_feedback_delay_core_tb;
	import sfd_pkg::*;

	localparam int DEPTH        = 131072;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 16;    // margin for the pipeline to drain
	localparam int HOLD_OFF     = 80;    // long enough to fill the 16-entry queue
	localparam int PHASE_ITEMS  = 70;    // six random phases, at least 420 transfers in all

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_wdata;
	int                errors;
	int                pending;
	int                cycles;
	int                sent;
	int                burst_left;
	int                phase_idx;

	sfd_in_if  feed ();
	sfd_out_if echo ();

	stutter_roll_feedback_delay_core #(
		.DELAY_DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_in (feed),
		.sample_out(echo)
	);

	// scoreboard sits beside the block and only watches
	sfd_echo_checker #(
		.DEPTH(DEPTH)
	) scoreboard (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.feed     (feed),
		.echo     (echo),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("stutter_roll_feedback_delay_core verification failed");
			$finish;
		end
	end

	// Receiver: switches at random among stall patterns (always ready, mostly
	// ready, mostly stalled). Once the second random phase starts, ready is
	// held low through a HOLD_OFF stretch while the sender keeps offering, so
	// the result queue fills and the block must drop its input ready.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		bit held_once;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		held_once = 1'b0;
		echo.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_idx == 1 && !held_once) begin
				held_once = 1'b1;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				echo.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: begin
						echo.ready <= 1'b1;
					end
					1: begin
						echo.ready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						echo.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Sender: bursts of random length, each preceded by a random gap (sometimes
	// none). valid stays high across back-to-back transfers; a gap lowers it in
	// a step of its own.
	task automatic send_pair(input sample_t l, input sample_t r,
			input logic [BEAT_W-1:0] beat, input logic [LVL_W-1:0] lvl, input logic on);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 5);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				feed.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		feed.valid       <= 1'b1;
		feed.in_left     <= l;
		feed.in_right    <= r;
		feed.beat_ms     <= beat;
		feed.level_depth <= lvl;
		feed.fx_on       <= on;
		do
			@(posedge clk);
		while (!feed.ready);
		burst_left--;
		sent++;
	endtask

	// let every expected result come back, then let the pipeline settle
	task automatic wait_idle();
		feed.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_rate(input logic [RATE_W-1:0] hz);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// full-scale corners show up often so the saturation paths get exercised
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return LVL_W'(FULL_Q15);
			2: return LVL_W'($urandom_range(32769, 65535));   // above full, clamps
			default: return LVL_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// short loops dominate so the taps land on freshly recorded audio and
	// the feedback builds up; the rest covers the clamp at the store depth
	function automatic logic [BEAT_W-1:0] pick_beat();
		case ($urandom_range(0, 9))
			0: return BEAT_W'($urandom);
			1, 2: return BEAT_W'($urandom_range(0, 20));
			default: return BEAT_W'($urandom_range(0, 3));
		endcase
	endfunction

	// One record-then-roll sequence: a dry stretch that records into the rings, a
	// rising fx_on that latches the loop length, then a held stretch whose
	// beat_ms is ignored. One in ten is plain fx_on noise instead.
	task automatic roll_sequence();
		int dry_len;
		int wet_len;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(4, 16))
				send_pair(pick_sample(), pick_sample(), BEAT_W'($urandom), pick_level(),
					1'($urandom));
		end else begin
			dry_len = $urandom_range(2, 24);
			wet_len = $urandom_range(1, 30);
			repeat (dry_len)
				send_pair(pick_sample(), pick_sample(), BEAT_W'($urandom), pick_level(), 1'b0);
			send_pair(pick_sample(), pick_sample(), pick_beat(), pick_level(), 1'b1);
			repeat (wet_len - 1)
				send_pair(pick_sample(), pick_sample(), BEAT_W'($urandom), pick_level(), 1'b1);
		end
	endtask

	initial begin
		logic [RATE_W-1:0] rates [6];
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		feed.valid       <= 1'b0;
		feed.in_left     <= '0;
		feed.in_right    <= '0;
		feed.beat_ms     <= '0;
		feed.level_depth <= '0;
		feed.fx_on       <= 1'b0;
		sent             = 0;
		burst_left       = 0;
		phase_idx        = -1;
		rates = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'($urandom), 18'd44100};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset rate of 48 kHz (48 samples per ms)
		send_pair(16'sh7FFF, 16'sh8000, '0, '0, 1'b0);           // pass-through corners
		send_pair(16'sh8000, 16'sh7FFF, '0, '0, 1'b0);
		send_pair(16'sh0000, 16'shFFFF, '0, '0, 1'b0);
		send_pair(16'sd12345, -16'sd12345, '0, '0, 1'b0);
		send_pair('0, '0, '0, 16'd32768, 1'b1);                   // rise, zero beat: delay 1
		send_pair(16'sh7FFF, 16'sh8000, '0, 16'hFFFF, 1'b1);     // level above full
		send_pair(16'sh7FFF, 16'sh8000, '0, 16'd16384, 1'b1);
		send_pair(16'sh7FFF, 16'sh8000, '0, 16'd32768, 1'b1);    // feedback saturates
		send_pair(16'shFFFF, 16'sh0001, '0, '0, 1'b1);           // level zero while held
		send_pair(16'sd100, -16'sd100, '0, 16'd20000, 1'b0);     // falling edge records
		send_pair(16'sd200, -16'sd200, '0, 16'd20000, 1'b0);
		send_pair(16'sd300, -16'sd300, 14'h3FFF, 16'd32768, 1'b1); // clamp to depth-1
		send_pair(16'sh8000, 16'sh7FFF, '0, 16'd40000, 1'b1);
		send_pair(16'sd1, -16'sd1, '0, 16'd32767, 1'b0);
		send_pair(16'sd2, -16'sd2, 14'd10000, 16'd20000, 1'b1);  // long beat, clamps too
		send_pair(16'sd3, -16'sd3, '0, 16'd32767, 1'b0);
		send_pair(16'sd4, -16'sd4, 14'd1, 16'd24576, 1'b1);      // 48 samples back
		send_pair(16'sh7FFF, 16'sh7FFF, 14'h2AAA, 16'h5555, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 14'h1555, 16'hAAAA, 1'b0);

		// random part: one phase per rate, extremes and out-of-range values included
		foreach (rates[i]) begin
			set_rate(rates[i]);
			phase_idx = i;
			sent = 0;
			while (sent < PHASE_ITEMS)
				roll_sequence();
		end

		wait_idle();
		if (errors == 0)
			$display("stutter_roll_feedback_delay_core verification clean");
		else
			$display("stutter_roll_feedback_delay_core verification failed");
		$finish;
	end

endmodule
